### rtl/nearest_smaller_index_stack_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest smaller index stack unit
// Concurrent checks clocked on clk; NSIU_ASSERT checks are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NEAREST_SMALLER_INDEX_STACK_UNIT_MACROS_SVH
`define NEAREST_SMALLER_INDEX_STACK_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define NSIU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NSIU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NSIU_ASSERT(lbl, prop, msg)
`define NSIU_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/nsi_pkg.sv
// ----------------------------------------------------------------------------
// nsi_pkg
// Shared constants and types of the nearest smaller index stack unit.
// ----------------------------------------------------------------------------
`default_nettype none

package nsi_pkg;

  localparam int STACK_DEPTH_DEF = 1024;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int POS_W           = 10;
  localparam int NEAR_W          = 11;

  typedef struct packed {
    logic clear;
    logic pop;
    logic push;
  } cell_ctrl_t;

  typedef struct packed {
    logic             top_valid;
    logic             full;
    logic [POS_W-1:0] top_pos;
  } stack_status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } nsi_state_t;

endpackage

`default_nettype wire

### rtl/nsi_in_if.sv
// ----------------------------------------------------------------------------
// nsi_in_if
// Input channel: one sample with its position and restart flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface nsi_in_if #(
  parameter int VALUE_WIDTH = nsi_pkg::VALUE_WIDTH_DEF
);
  import nsi_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] sample_value;
  logic        [POS_W-1:0]       sample_position;
  logic                          restart;

  modport source (output valid, sample_value, sample_position, restart, input ready);
  modport sink   (input valid, sample_value, sample_position, restart, output ready);
endinterface

`default_nettype wire

### rtl/nsi_out_if.sv
// ----------------------------------------------------------------------------
// nsi_out_if
// Result channel: nearest smaller position and overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface nsi_out_if;
  import nsi_pkg::*;

  logic              valid;
  logic              ready;
  logic [NEAR_W-1:0] nearest_position;
  logic              overflow;

  modport source (output valid, nearest_position, overflow, input ready);
  modport sink   (input valid, nearest_position, overflow, output ready);
endinterface

`default_nettype wire

### rtl/nsi_cell.sv
// ----------------------------------------------------------------------------
// nsi_cell
// One stack entry. Empties on a clear, takes the entry below on a pop, the entry above on a push.
// ----------------------------------------------------------------------------
`default_nettype none

module nsi_cell #(
  parameter int VALUE_WIDTH = nsi_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire nsi_pkg::cell_ctrl_t      ctrl,
  input  wire logic                     above_valid,
  input  wire logic [VALUE_WIDTH-1:0]   above_value,
  input  wire logic [nsi_pkg::POS_W-1:0] above_pos,
  input  wire logic                     below_valid,
  input  wire logic [VALUE_WIDTH-1:0]   below_value,
  input  wire logic [nsi_pkg::POS_W-1:0] below_pos,
  output logic                          ent_valid,
  output logic [VALUE_WIDTH-1:0]        ent_value,
  output logic [nsi_pkg::POS_W-1:0]     ent_pos
);
  import nsi_pkg::*;

  logic                   valid_r, valid_nxt;
  logic [VALUE_WIDTH-1:0] value_r, value_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    pos_nxt   = pos_r;
    if (ctrl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctrl.pop) begin
      valid_nxt = below_valid;
      value_nxt = below_value;
      pos_nxt   = below_pos;
    end else if (ctrl.push) begin
      valid_nxt = above_valid;
      value_nxt = above_value;
      pos_nxt   = above_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    pos_r   <= pos_nxt;
  end

  assign ent_valid = valid_r;
  assign ent_value = value_r;
  assign ent_pos   = pos_r;

endmodule

`default_nettype wire

### rtl/nsi_ctrl.sv
// ----------------------------------------------------------------------------
// nsi_ctrl
// Sequencer: holds the current sample, pops while the top is not smaller,
// then registers the result and pushes the sample unless the stack is full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nearest_smaller_index_stack_unit_macros.svh"

module nsi_ctrl #(
  parameter int VALUE_WIDTH = nsi_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  nsi_in_if.sink                         in_ch,
  nsi_out_if.source                      out_ch,
  input  wire nsi_pkg::stack_status_t    status,
  input  wire logic [VALUE_WIDTH-1:0]    top_value,
  output nsi_pkg::cell_ctrl_t            cell_ctrl,
  output logic [VALUE_WIDTH-1:0]         push_value,
  output logic [nsi_pkg::POS_W-1:0]      push_pos
);
  import nsi_pkg::*;

  nsi_state_t             state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] key_r, key_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [NEAR_W-1:0]      near_r, near_nxt;
  logic                   ovf_r, ovf_nxt;

  logic pop_hit;
  logic out_free;
  logic finish;
  logic accept;

  assign pop_hit     = status.top_valid && ($signed(top_value) >= $signed(key_r));
  assign out_free    = !out_valid_r || out_ch.ready;
  assign finish      = (state_r == ST_SCAN) && !pop_hit && out_free;
  assign in_ch.ready = (state_r == ST_IDLE) || finish;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    cell_ctrl.clear = accept && in_ch.restart;
    cell_ctrl.pop   = (state_r == ST_SCAN) && pop_hit;
    cell_ctrl.push  = finish && !status.full;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (finish && !accept) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    key_nxt       = key_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    near_nxt      = near_r;
    ovf_nxt       = ovf_r;
    if (accept) begin
      key_nxt = in_ch.sample_value;
      pos_nxt = in_ch.sample_position;
    end
    if (finish) begin
      out_valid_nxt = 1'b1;
      near_nxt      = status.top_valid ? ({1'b0, status.top_pos} + NEAR_W'(1)) : '0;
      ovf_nxt       = status.full;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    pos_r  <= pos_nxt;
    near_r <= near_nxt;
    ovf_r  <= ovf_nxt;
  end

  assign push_value              = key_r;
  assign push_pos                = pos_r;
  assign out_ch.valid            = out_valid_r;
  assign out_ch.nearest_position = near_r;
  assign out_ch.overflow         = ovf_r;

  `NSIU_ASSERT(a_pop_needs_entry, cell_ctrl.pop |-> status.top_valid, "pop on empty stack")
  `NSIU_ASSERT(a_no_push_full, cell_ctrl.push |-> !status.full, "push onto full stack")
  `NSIU_ASSERT(a_restart_empties, (accept && in_ch.restart) |=> !status.top_valid, "restart left entries")
  `NSIU_ASSERT(a_result_waits, (state_r == ST_SCAN && !pop_hit && !out_free) |=> (state_r == ST_SCAN), "result dropped while output busy")
  `NSIU_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == ST_IDLE && !out_valid_r), "reset did not idle sequencer")

endmodule

`default_nettype wire

### rtl/nearest_smaller_index_stack_unit.sv
// Flow: once a sample is taken, the entries that are not smaller than it are popped, one pop
// per cycle at the top cell, and the result lands in the output register once it is free.
// A new sample is not taken while pops are pending; the next sample is taken in the cycle
// the current result is registered.
// Reset: synchronous, active low; empties the stack and clears the output valid.
// ----------------------------------------------------------------------------
// nearest_smaller_index_stack_unit
// Monotonic stack built as a chain of cells that shift toward the top on a pop
// and away from it on a push.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_smaller_index_stack_unit #(
  parameter int STACK_DEPTH = nsi_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = nsi_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  nsi_in_if.sink    in_ch,
  nsi_out_if.source out_ch
);
  import nsi_pkg::*;

  cell_ctrl_t             cell_ctrl;
  stack_status_t          status;
  logic [VALUE_WIDTH-1:0] push_value;
  logic [POS_W-1:0]       push_pos;

  logic                   c_valid [STACK_DEPTH];
  logic [VALUE_WIDTH-1:0] c_value [STACK_DEPTH];
  logic [POS_W-1:0]       c_pos   [STACK_DEPTH];

  nsi_ctrl #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .status     (status),
    .top_value  (c_value[0]),
    .cell_ctrl  (cell_ctrl),
    .push_value (push_value),
    .push_pos   (push_pos)
  );

  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    logic                   a_valid, b_valid;
    logic [VALUE_WIDTH-1:0] a_value, b_value;
    logic [POS_W-1:0]       a_pos, b_pos;

    if (g == 0) begin : g_top
      assign a_valid = 1'b1;
      assign a_value = push_value;
      assign a_pos   = push_pos;
    end else begin : g_mid_a
      assign a_valid = c_valid[g-1];
      assign a_value = c_value[g-1];
      assign a_pos   = c_pos[g-1];
    end

    if (g == STACK_DEPTH - 1) begin : g_bottom
      assign b_valid = 1'b0;
      assign b_value = '0;
      assign b_pos   = '0;
    end else begin : g_mid_b
      assign b_valid = c_valid[g+1];
      assign b_value = c_value[g+1];
      assign b_pos   = c_pos[g+1];
    end

    nsi_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (cell_ctrl),
      .above_valid (a_valid),
      .above_value (a_value),
      .above_pos   (a_pos),
      .below_valid (b_valid),
      .below_value (b_value),
      .below_pos   (b_pos),
      .ent_valid   (c_valid[g]),
      .ent_value   (c_value[g]),
      .ent_pos     (c_pos[g])
    );
  end

  always_comb begin
    status.top_valid = c_valid[0];
    status.full      = c_valid[STACK_DEPTH-1];
    status.top_pos   = c_pos[0];
  end

endmodule

`default_nettype wire
